### rtl/rspg_pkg.sv
// ----------------------------------------------------------------------------
// rspg_pkg
// Shared widths, register codes, format codes and types of the resonator
// sine PCM generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rspg_pkg;

    // Default sizes
    localparam int FRAC_BITS_DEF    = 30;
    localparam int MAX_CHANNELS_DEF = 8;

    // Port widths
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int INDEX_W   = 3;
    localparam int FMT_W     = 2;
    localparam int CCOUNT_W  = 4;

    // Widened channel count for compare against the channel limit (up to 63)
    localparam int CNT_EXT_W = 6;

    // Normalizing frame for the float path: magnitude is at most 2^30
    localparam int NORM_W = 31;
    localparam int LEAD_W = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = 3'd4;

    // Sample formats
    localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_I16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_I32 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_F32 = 2'd3;

    // Configuration register file
    typedef struct packed {
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] start_y1;
        logic signed [DATA_W-1:0] start_y2;
        logic [FMT_W-1:0]         fmt;
        logic [CCOUNT_W-1:0]      chan_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        coef:       32'sd2140862955,
        start_y1:   -32'sd84244709,
        start_y2:   -32'sd167969728,
        fmt:        FMT_I16,
        chan_count: 4'd2
    };

    // New sample from the recurrence
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } samp_t;

    // Converted PCM word
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] word;
    } word_t;

endpackage

`default_nettype wire

### rtl/rspg_ifs.sv
// ----------------------------------------------------------------------------
// rspg tick and PCM channels
// Valid/ready channels for tick requests and emitted PCM words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rspg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rspg_pcm_if;
    import rspg_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  sample_word;
    logic [INDEX_W-1:0] channel_index;
    logic               last_of_frame;

    modport source (output valid, output sample_word, output channel_index,
                    output last_of_frame, input ready);
    modport sink   (input valid, input sample_word, input channel_index,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/rspg_recur.sv
// ----------------------------------------------------------------------------
// rspg_recur
// Two-pole resonator step y0 = coef*y1 - y2 with rounding and saturation;
// holds the oscillator state and registers the new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module rspg_recur #(
    parameter int FRAC_BITS = rspg_pkg::FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rspg_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          restart,
    output rspg_pkg::samp_t    y,
    input  wire logic          y_ready
);
    import rspg_pkg::*;

    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint SAT_HI = (2 * ONE_L > 64'sd2147483647) ? 64'sd2147483647 : 2 * ONE_L;
    localparam longint SAT_LO = (-2 * ONE_L < -64'sd2147483648) ? -64'sd2147483648
                                                                : -2 * ONE_L;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [DATA_W-1:0] y1_reg, y2_reg;
    logic signed [DATA_W-1:0] y0_reg;
    logic                     valid_reg;

    logic signed [DATA_W-1:0] y1_sel, y2_sel;
    logic signed [63:0]       prod, rnd, y0_full;
    logic signed [DATA_W-1:0] y0_next;
    logic                     accept;

    assign in_ready = !valid_reg || y_ready;
    assign accept   = in_valid && in_ready;

    // Restart reloads the start values ahead of this tick
    assign y1_sel = restart ? cfg.start_y1 : y1_reg;
    assign y2_sel = restart ? cfg.start_y2 : y2_reg;

    // Product, round half up, subtract, saturate
    always_comb
    begin
        prod    = y1_sel * cfg.coef;
        rnd     = prod + HALF;
        y0_full = (rnd >>> FRAC_BITS) - 64'(y2_sel);
        if (y0_full > SAT_HI)
            y0_next = 32'(SAT_HI);
        else if (y0_full < SAT_LO)
            y0_next = 32'(SAT_LO);
        else
            y0_next = y0_full[DATA_W-1:0];
    end

    // Oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg <= CFG_RESET.start_y1;
            y2_reg <= CFG_RESET.start_y2;
        end
        else if (accept)
        begin
            y1_reg <= y0_next;
            y2_reg <= y1_sel;
        end
    end

    // Sample register toward conversion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (y_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            y0_reg <= y0_next;
    end

    assign y.valid = valid_reg;
    assign y.value = y0_reg;

endmodule

`default_nettype wire

### rtl/rspg_conv.sv
// ----------------------------------------------------------------------------
// rspg_conv
// Clamps the sample to [-1, 1] and converts it to the selected PCM word:
// stage one finds sign, magnitude and leading one, stage two forms the word.
// ----------------------------------------------------------------------------
`default_nettype none

module rspg_conv #(
    parameter int FRAC_BITS = rspg_pkg::FRAC_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rspg_pkg::cfg_t  cfg,
    input  wire rspg_pkg::samp_t y,
    output logic                 y_ready,
    output rspg_pkg::word_t      w,
    input  wire logic            w_ready
);
    import rspg_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE_S   = 32'sd1 <<< FRAC_BITS;
    localparam logic [FRAC_BITS+1:0]     ONE_U   = (FRAC_BITS+2)'(1) << FRAC_BITS;
    localparam logic [7:0]               EXP_OFS = 8'(127 - FRAC_BITS);

    // Stage one registers
    logic                 v1_reg;
    logic                 neg_reg;
    logic [FRAC_BITS:0]   mag_reg;
    logic [LEAD_W-1:0]    lead_reg;

    // Stage two registers
    logic                 v2_reg;
    logic [DATA_W-1:0]    word_reg;

    logic                     s2_free;
    logic signed [DATA_W-1:0] clamped;
    logic [DATA_W-1:0]        abs_val;
    logic [NORM_W-1:0]        mag_in;
    logic [LEAD_W-1:0]        lead;

    logic [NORM_W-1:0]        mag_n;
    logic [NORM_W-1:0]        norm;
    logic [23:0]              q;
    logic                     round_up;
    logic [24:0]              q_rnd;
    logic [7:0]               exp_f;
    logic [DATA_W-1:0]        word_f32;

    logic [FRAC_BITS+1:0]     u;
    logic [FRAC_BITS+9:0]     p8;
    logic [FRAC_BITS+15:0]    p16;
    logic [FRAC_BITS+31:0]    p32;
    logic [15:0]              m16, i16;
    logic [DATA_W-1:0]        m32, i32;
    logic [DATA_W-1:0]        word_next;

    assign s2_free = !v2_reg || w_ready;
    assign y_ready = !v1_reg || s2_free;

    // Clamp, magnitude, leading one
    always_comb
    begin
        if (y.value > ONE_S)
            clamped = ONE_S;
        else if (y.value < -ONE_S)
            clamped = -ONE_S;
        else
            clamped = y.value;
        abs_val = clamped[DATA_W-1] ? 32'(-clamped) : 32'(clamped);
        mag_in  = NORM_W'(abs_val[FRAC_BITS:0]);
        lead    = '0;
        for (int i = 0; i < NORM_W; i++)
        begin
            if (mag_in[i])
                lead = LEAD_W'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (y.valid && y_ready)
            v1_reg <= 1'b1;
        else if (s2_free)
            v1_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (y.valid && y_ready)
        begin
            neg_reg  <= clamped[DATA_W-1];
            mag_reg  <= abs_val[FRAC_BITS:0];
            lead_reg <= lead;
        end
    end

    // Offset uint8: (one + c) * 255 / (2 * one)
    assign u  = neg_reg ? ONE_U - (FRAC_BITS+2)'(mag_reg) : ONE_U + (FRAC_BITS+2)'(mag_reg);
    assign p8 = {u, 8'b0} - (FRAC_BITS+10)'(u);

    // int16 and int32: magnitude times full scale, truncated, sign applied
    assign p16 = {mag_reg, 15'b0} - (FRAC_BITS+16)'(mag_reg);
    assign m16 = p16[FRAC_BITS+15:FRAC_BITS];
    assign i16 = neg_reg ? 16'(-m16) : m16;
    assign p32 = {mag_reg, 31'b0} - (FRAC_BITS+32)'(mag_reg);
    assign m32 = p32[FRAC_BITS+31:FRAC_BITS];
    assign i32 = neg_reg ? 32'(-m32) : m32;

    // float32: normalize to bit 30, round to nearest even on the low 7 bits
    always_comb
    begin
        mag_n    = NORM_W'(mag_reg);
        norm     = mag_n << (LEAD_W'(NORM_W - 1) - lead_reg);
        q        = norm[NORM_W-1:NORM_W-24];
        round_up = norm[6] && ((|norm[5:0]) || q[0]);
        q_rnd    = {1'b0, q} + 25'(round_up);
        exp_f    = 8'(lead_reg) + EXP_OFS + 8'(q_rnd[24]);
        if (mag_reg == '0)
            word_f32 = '0;
        else
            word_f32 = {neg_reg, exp_f, q_rnd[22:0]};
    end

    // Format select
    always_comb
    begin
        unique case (cfg.fmt)
            FMT_U8:  word_next = 32'(p8[FRAC_BITS+8:FRAC_BITS+1]);
            FMT_I16: word_next = 32'(i16);
            FMT_I32: word_next = i32;
            FMT_F32: word_next = word_f32;
            default: word_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (s2_free)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && v1_reg)
            word_reg <= word_next;
    end

    assign w.valid = v2_reg;
    assign w.word  = word_reg;

endmodule

`default_nettype wire

### rtl/rspg_emit.sv
// ----------------------------------------------------------------------------
// rspg_emit
// Output register: repeats one PCM word once per channel and flags the last.
// ----------------------------------------------------------------------------
`default_nettype none

module rspg_emit #(
    parameter int MAX_CHANNELS = rspg_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rspg_pkg::cfg_t  cfg,
    input  wire rspg_pkg::word_t w,
    output logic                 w_ready,
    rspg_pcm_if.source           pcm
);
    import rspg_pkg::*;

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CNT_EXT_W-1:0] MAX_C = CNT_EXT_W'(MAX_CHANNELS);

    logic              valid_reg;
    logic [CW-1:0]     chan_reg;
    logic [DATA_W-1:0] word_reg;

    logic [CNT_EXT_W-1:0] cc_ext, last_ext;
    logic [CW-1:0]        last_idx;
    logic                 is_last;
    logic                 take;
    logic [DATA_W-1:0]    chan_ext;

    // Channel count zero acts as one, above the limit acts as the limit
    always_comb
    begin
        cc_ext = CNT_EXT_W'(cfg.chan_count);
        if (cc_ext == '0)
            last_ext = '0;
        else if (cc_ext > MAX_C)
            last_ext = MAX_C - 1'b1;
        else
            last_ext = cc_ext - 1'b1;
    end

    assign last_idx = last_ext[CW-1:0];
    assign is_last  = (chan_reg == last_idx);
    assign take     = valid_reg && pcm.ready;
    assign w_ready  = !valid_reg || (pcm.ready && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            chan_reg  <= '0;
        end
        else if (w.valid && w_ready)
        begin
            valid_reg <= 1'b1;
            chan_reg  <= '0;
        end
        else if (take)
        begin
            if (is_last)
                valid_reg <= 1'b0;
            else
                chan_reg <= chan_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w.valid && w_ready)
            word_reg <= w.word;
    end

    assign chan_ext          = DATA_W'(chan_reg);
    assign pcm.valid         = valid_reg;
    assign pcm.sample_word   = word_reg;
    assign pcm.channel_index = chan_ext[INDEX_W-1:0];
    assign pcm.last_of_frame = is_last;

endmodule

`default_nettype wire

### rtl/resonator_sine_pcm_generator_top.sv
// Latency: an accepted tick passes the recurrence register, the conversion
// stages (normalize, convert) and the output register; its words then leave
// one per cycle while the PCM sink is ready. Throughput: each tick yields N
// words, N the effective channel count (1 to MAX_CHANNELS).
// Reset: control and configuration registers take their reset values; the
// oscillator state loads the reset start values; no clearing pass.
// ----------------------------------------------------------------------------
// resonator_sine_pcm_generator_top
// Two-pole resonator sine source with configurable PCM format and channel
// replication.
// ----------------------------------------------------------------------------
`default_nettype none

module resonator_sine_pcm_generator_top #(
    parameter int MAX_CHANNELS = rspg_pkg::MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = rspg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rspg_tick_if.sink                              tick,
    rspg_pcm_if.source                             pcm,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rspg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rspg_pkg::DATA_W-1:0]       cfg_data
);
    import rspg_pkg::*;

    cfg_t  cfg_reg;
    samp_t y_s;
    logic  y_ready;
    word_t w_s;
    logic  w_ready;
    logic  tick_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_COEF:       cfg_reg.coef       <= cfg_data;
                REG_START_Y1:   cfg_reg.start_y1   <= cfg_data;
                REG_START_Y2:   cfg_reg.start_y2   <= cfg_data;
                REG_FORMAT:     cfg_reg.fmt        <= cfg_data[FMT_W-1:0];
                REG_CHAN_COUNT: cfg_reg.chan_count <= cfg_data[CCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Resonator step
    rspg_recur #(
        .FRAC_BITS (FRAC_BITS)
    ) u_recur (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (tick.valid),
        .in_ready (tick_ready),
        .restart  (tick.restart),
        .y        (y_s),
        .y_ready  (y_ready)
    );

    assign tick.ready = tick_ready;

    // PCM conversion
    rspg_conv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_conv (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .y       (y_s),
        .y_ready (y_ready),
        .w       (w_s),
        .w_ready (w_ready)
    );

    // Channel replication
    rspg_emit #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .w       (w_s),
        .w_ready (w_ready),
        .pcm     (pcm)
    );

endmodule

`default_nettype wire

### rtl/rspg_checker.sv
// ----------------------------------------------------------------------------
// rspg_checker
// Port-level checks on the PCM word stream of the generator.
// ----------------------------------------------------------------------------
`default_nettype none

module rspg_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           pcm_valid,
    input wire logic                           pcm_ready,
    input wire logic [rspg_pkg::DATA_W-1:0]    pcm_word,
    input wire logic [rspg_pkg::INDEX_W-1:0]   pcm_index,
    input wire logic                           pcm_last
);
    import rspg_pkg::*;

    logic take;
    assign take = pcm_valid && pcm_ready;

    // Stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid && !pcm_ready |=> pcm_valid && $stable(pcm_word)
            && $stable(pcm_index) && $stable(pcm_last))
        else $error("pcm word changed while stalled");

    // Within a frame the next word follows at once with the next slot
    a_next_slot: assert property (@(posedge clk) disable iff (!rst_n)
        take && !pcm_last |=> pcm_valid && (pcm_index == $past(pcm_index) + 1'b1))
        else $error("channel slot did not advance");

    // All words of a frame carry the same sample
    a_same_word: assert property (@(posedge clk) disable iff (!rst_n)
        take && !pcm_last |=> pcm_word == $past(pcm_word))
        else $error("sample word changed within a frame");

    // A new frame starts at slot zero
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        take && pcm_last |=> !pcm_valid || (pcm_index == '0))
        else $error("frame did not start at slot zero");

endmodule

bind resonator_sine_pcm_generator_top rspg_checker u_rspg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pcm_valid (pcm.valid),
    .pcm_ready (pcm.ready),
    .pcm_word  (pcm.sample_word),
    .pcm_index (pcm.channel_index),
    .pcm_last  (pcm.last_of_frame)
);

`default_nettype wire
